### rtl/i2c_master_transaction_sequencer_macros.svh
// Assertion macros for the two-wire bus master sequencer.
// Used by the checker module only; depends on nothing else.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define I2CMTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The expression must never be true outside reset.
`define I2CMTS_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

### rtl/i2cmts_pkg.sv
// Shared types and codes for the two-wire bus master sequencer.
// Used by the top level, its output stage and its checker.
package i2cmts_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_EVENT = 2'd3;

    localparam logic [3:0] EV_START      = 4'd0;
    localparam logic [3:0] EV_RESTART    = 4'd1;
    localparam logic [3:0] EV_ADDR_W_ACK = 4'd2;
    localparam logic [3:0] EV_DATA_TX_ACK = 4'd3;
    localparam logic [3:0] EV_DATA_RX_ACK = 4'd4;
    localparam logic [3:0] EV_ADDR_R_ACK = 4'd5;
    localparam logic [3:0] EV_DATA_RX_NACK = 4'd6;
    localparam logic [3:0] EV_ARB_LOST   = 4'd7;
    localparam logic [3:0] EV_OTHER      = 4'd12;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_SEND    = 3'd1;
    localparam logic [2:0] ACT_RX_ACK  = 3'd2;
    localparam logic [2:0] ACT_RX_NACK = 3'd3;
    localparam logic [2:0] ACT_STOP    = 3'd4;
    localparam logic [2:0] ACT_START   = 3'd5;
    localparam logic [2:0] ACT_RELEASE = 3'd6;

    localparam logic [3:0] ERR_NONE = 4'd0;
    localparam logic [3:0] ERR_SAT  = 4'd13;

    typedef struct packed {
        logic [2:0] action;
        logic       tx_sel;
        logic       rd_sel;
        logic       busy;
        logic       ok;
        logic [3:0] err;
    } t_info;

endpackage

### rtl/i2cmts_out_stage.sv
// Result pipeline: merges the buffer read data with the decided result and
// holds it in an output register. Depends on i2cmts_pkg.
module i2cmts_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i2cmts_pkg::t_info   i_info,
    input  logic [7:0]          i_mem_q,
    output logic                o_can_push,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_bus_action,
    output logic [7:0]          o_transmit_byte,
    output logic [7:0]          o_read_data,
    output logic                o_busy_res,
    output logic                o_last_ok,
    output logic [3:0]          o_error_code
);
    import i2cmts_pkg::*;

    logic  r_s1_valid;
    t_info r_s1_info;
    logic  r_out_valid;
    logic  advance;

    assign advance    = r_s1_valid && (!r_out_valid || i_ready);
    assign o_can_push = !r_s1_valid || advance;
    assign o_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s1_info <= i_info;
        end
        if (advance) begin
            o_bus_action    <= r_s1_info.action;
            o_transmit_byte <= r_s1_info.tx_sel ? i_mem_q : 8'd0;
            o_read_data     <= r_s1_info.rd_sel ? i_mem_q : 8'd0;
            o_busy_res      <= r_s1_info.busy;
            o_last_ok       <= r_s1_info.ok;
            o_error_code    <= r_s1_info.err;
        end
    end

endmodule

### rtl/i2c_master_transaction_sequencer.sv
// Top level of the two-wire bus master transaction sequencer.
// Depends on i2cmts_pkg and i2cmts_out_stage.
//
// Usage: each request on the input channel (i_valid / o_ready) carries an
// opcode: load a buffer byte, read a buffer byte, start a transaction, or
// report a bus status event. Every request gives exactly one result on the
// output channel (o_valid / i_ready) with the next bus action, the byte to
// transmit, the read data and the busy, success and error status.
// The state flags are updated when the request is taken, and the message
// buffer is a synchronous memory read at the same clock edge; the read data
// and the decision pass through one holding stage and the output register.
// The decision and read data are registered in the holding stage and then in the
// output register, which drives o_valid. A new request is taken every cycle while
// the receiver takes the results, so the throughput is one request per cycle.
// A synchronous active-low reset clears the flags, pointer and size and
// empties the pipeline; buffer contents are undefined until written.
// When the receiver stalls, the output register and the holding stage fill
// and o_ready drops until the result is taken.
module i2c_master_transaction_sequencer #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [4:0] i_index,
    input  logic [7:0] i_load_byte,
    input  logic [5:0] i_message_size,
    input  logic [3:0] i_bus_event,
    input  logic [7:0] i_received_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_bus_action,
    output logic [7:0] o_transmit_byte,
    output logic [7:0] o_read_data,
    output logic       o_busy_res,
    output logic       o_last_ok,
    output logic [3:0] o_error_code
);
    import i2cmts_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int PW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = (PW > 6) ? PW : 6;

    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_mem_q;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [PW-1:0] r_size, n_size;
    logic          r_busy, n_busy;
    logic          r_ok, n_ok;
    logic [3:0]    r_err, n_err;

    logic          accept;
    logic          can_push;
    logic          idx_ok;
    logic [SW-1:0] size_ext;
    logic [SW-1:0] size_sat;
    logic [PW-1:0] ptr_base;
    logic [PW-1:0] ptr_bump;
    logic [PW-1:0] rx_ptr;
    logic          ptr_in_buf;
    logic          tx_more;
    logic          rx_last;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    wr_data;
    t_info         info;

    assign o_ready = can_push;
    assign accept  = i_valid && can_push;

    assign idx_ok     = 32'(i_index) < 32'(BUFFER_DEPTH);
    assign size_ext   = SW'(i_message_size);
    assign size_sat   = (size_ext > SW'(BUFFER_DEPTH)) ? SW'(BUFFER_DEPTH) : size_ext;
    assign ptr_in_buf = r_ptr < PW'(BUFFER_DEPTH);
    assign ptr_bump   = ptr_in_buf ? r_ptr + PW'(1) : r_ptr;
    assign ptr_base   = (i_bus_event == EV_START || i_bus_event == EV_RESTART) ? '0 : r_ptr;
    assign tx_more    = (ptr_base < r_size) && (ptr_base < PW'(BUFFER_DEPTH));
    assign rx_ptr     = (i_bus_event == EV_DATA_RX_ACK) ? ptr_bump : r_ptr;
    assign rx_last    = ({1'b0, rx_ptr} + (PW+1)'(1)) >= {1'b0, r_size};

    always_comb begin
        n_ptr   = r_ptr;
        n_size  = r_size;
        n_busy  = r_busy;
        n_ok    = r_ok;
        n_err   = r_err;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        wr_addr = AW'(i_index);
        rd_addr = AW'(i_index);
        wr_data = i_load_byte;
        info    = '0;
        unique case (i_opcode)
            OP_LOAD: begin
                mem_we = idx_ok;
            end
            OP_READ: begin
                mem_re      = idx_ok;
                info.rd_sel = idx_ok;
            end
            OP_START: begin
                if (!r_busy) begin
                    n_size      = PW'(size_sat);
                    n_busy      = 1'b1;
                    n_ok        = 1'b0;
                    n_err       = ERR_NONE;
                    info.action = ACT_START;
                end
            end
            OP_EVENT: begin
                if (r_busy) begin
                    case (i_bus_event) inside
                        EV_START, EV_RESTART, EV_ADDR_W_ACK, EV_DATA_TX_ACK: begin
                            rd_addr = AW'(ptr_base);
                            if (tx_more) begin
                                mem_re      = 1'b1;
                                info.tx_sel = 1'b1;
                                info.action = ACT_SEND;
                                n_ptr       = ptr_base + PW'(1);
                            end else begin
                                n_ptr       = ptr_base;
                                n_ok        = 1'b1;
                                n_busy      = 1'b0;
                                info.action = ACT_STOP;
                            end
                        end
                        EV_DATA_RX_ACK, EV_ADDR_R_ACK: begin
                            if (i_bus_event == EV_DATA_RX_ACK) begin
                                wr_addr = AW'(r_ptr);
                                wr_data = i_received_byte;
                                mem_we  = ptr_in_buf;
                                n_ptr   = ptr_bump;
                            end
                            info.action = rx_last ? ACT_RX_NACK : ACT_RX_ACK;
                        end
                        EV_DATA_RX_NACK: begin
                            wr_addr     = AW'(r_ptr);
                            wr_data     = i_received_byte;
                            mem_we      = ptr_in_buf;
                            n_ok        = 1'b1;
                            n_busy      = 1'b0;
                            info.action = ACT_STOP;
                        end
                        EV_ARB_LOST: begin
                            info.action = ACT_START;
                        end
                        default: begin
                            n_err       = (i_bus_event >= EV_OTHER) ? ERR_SAT
                                                                    : i_bus_event + 4'd1;
                            n_busy      = 1'b0;
                            info.action = ACT_RELEASE;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
        info.busy = n_busy;
        info.ok   = n_ok;
        info.err  = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (accept && mem_re) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_size <= '0;
            r_busy <= 1'b0;
            r_ok   <= 1'b0;
            r_err  <= ERR_NONE;
        end else if (accept) begin
            r_ptr  <= n_ptr;
            r_size <= n_size;
            r_busy <= n_busy;
            r_ok   <= n_ok;
            r_err  <= n_err;
        end
    end

    i2cmts_out_stage u_out_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (accept),
        .i_info          (info),
        .i_mem_q         (r_mem_q),
        .o_can_push      (can_push),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_bus_action    (o_bus_action),
        .o_transmit_byte (o_transmit_byte),
        .o_read_data     (o_read_data),
        .o_busy_res      (o_busy_res),
        .o_last_ok       (o_last_ok),
        .o_error_code    (o_error_code)
    );

endmodule

### rtl/i2cmts_checker.sv
// Port-level checker for the two-wire bus master sequencer, bound to the top.
// Depends on i2cmts_pkg and the assertion macro header.
`include "i2c_master_transaction_sequencer_macros.svh"

module i2cmts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [1:0] i_opcode,
    input logic [4:0] i_index,
    input logic [7:0] i_load_byte,
    input logic [5:0] i_message_size,
    input logic [3:0] i_bus_event,
    input logic [7:0] i_received_byte,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_bus_action,
    input logic [7:0] o_transmit_byte,
    input logic [7:0] o_read_data,
    input logic       o_busy_res,
    input logic       o_last_ok,
    input logic [3:0] o_error_code
);
    import i2cmts_pkg::*;

    `I2CMTS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_bus_action) && $stable(o_transmit_byte) && $stable(o_read_data), "stalled result changed")
    `I2CMTS_NEVER(a_tx_zero, i_clk, i_rst_n, o_valid && o_bus_action != ACT_SEND && o_transmit_byte != 8'd0, "transmit byte without send action")
    `I2CMTS_NEVER(a_busy_flags, i_clk, i_rst_n, o_valid && o_busy_res && (o_last_ok || o_error_code != ERR_NONE), "busy together with completion status")
    `I2CMTS_ASSERT(a_release, i_clk, i_rst_n, o_valid && o_bus_action == ACT_RELEASE |-> !o_busy_res && o_error_code != ERR_NONE, "release without recorded error")

endmodule

bind i2c_master_transaction_sequencer i2cmts_checker u_i2cmts_checker (.*);
